/* rtl/asd_pkg.sv */
// ----------------------------------------------------------------------------
// Adaptive silence detector package
// Shared widths, constants, types and the loudness breakpoint table.
// ----------------------------------------------------------------------------
package asd_pkg;

	localparam int ENERGY_W      = 16;
	localparam int RAW_IDX_W     = ENERGY_W - 3;
	localparam int LOUD_W        = 8;
	localparam int THRESH_W      = 9;
	localparam int PAROLE_W      = 8;
	localparam int EVAL_W        = 10;
	localparam int CNT_W         = 11;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 10;

	localparam int VU_TABLE_DEPTH_DEF = 4096;
	localparam int VU_TABLE_DEPTH_MAX = 8192;

	localparam int LOUD_LEVELS = 256;
	localparam int LOUD_TOP    = 254;
	localparam int BP_W        = 14;

	localparam logic [THRESH_W-1:0] THRESH_MAX = 9'd511;
	localparam logic [CNT_W-1:0]    CNT_MAX    = 11'd2047;

	localparam logic [PAROLE_W-1:0] PAROLE_RST = 8'd6;
	localparam logic [EVAL_W-1:0]   EVAL_RST   = 10'd24;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAROLE = 1'd0,
		CFG_EVAL   = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		logic              restart;
		logic [LOUD_W-1:0] loud;
	} mid_item_t;

	typedef struct packed {
		logic                silent;
		logic [THRESH_W-1:0] threshold;
		logic                in_parole;
	} res_item_t;

	typedef logic [BP_W-1:0] bp_tab_t [0:LOUD_LEVELS-1];

	// Entry k holds the first table index whose loudness is at least k.
	// Levels that are never reached hold all ones, above every index.
	function automatic bp_tab_t loud_bp_build();
		bp_tab_t      bp;
		logic [63:0]  term;
		logic [63:0]  c;
		logic [63:0]  e;
		logic [127:0] prod;
		logic [127:0] lhs;
		logic [127:0] rhs;
		logic         more;
		int unsigned  n;
		int unsigned  i;
		int unsigned  k;
		for (int j = 0; j < LOUD_LEVELS; j++) begin
			bp[j] = '1;
		end
		bp[0] = '0;
		term = 64'h8000_0000_0000_0000;
		c = term;
		n = 1;
		while (term != 64'd0) begin
			term = term / 64'(125 * n);
			c = c + term;
			n++;
		end
		e = 64'd1 << 53;
		k = 0;
		i = 1;
		while (k < LOUD_TOP && i < VU_TABLE_DEPTH_MAX) begin
			prod = 128'(e) * 128'(c);
			e = prod[126:63];
			more = 1'b1;
			while (more && k < LOUD_TOP) begin
				lhs = 128'(e) * 128'(LOUD_TOP - k);
				rhs = 128'(256 + k) << 53;
				if (lhs >= rhs) begin
					k++;
					bp[k] = BP_W'(i);
				end else begin
					more = 1'b0;
				end
			end
			i++;
		end
		return bp;
	endfunction

	localparam bp_tab_t LOUD_BP = loud_bp_build();

endpackage

/* rtl/asd_fifo.sv */
// ----------------------------------------------------------------------------
// Small register queue
// Holds a few beats between two sides so that each may stall on its own.
// ----------------------------------------------------------------------------
module asd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/asd_front.sv */
// ----------------------------------------------------------------------------
// Adaptive silence detector front end
// Takes beats in, saturates the table index and finds the loudness by a
// pipelined binary search over the breakpoint table, one bit per stage.
// ----------------------------------------------------------------------------
module asd_front #(
	parameter int VU_TABLE_DEPTH = asd_pkg::VU_TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [asd_pkg::ENERGY_W-1:0]  energy,
	input  logic                          restart,
	output logic                          mid_push,
	output asd_pkg::mid_item_t            mid_item,
	input  logic                          mid_full
);

	import asd_pkg::*;

	localparam int IDX_W  = $clog2(VU_TABLE_DEPTH);
	localparam int STAGES = LOUD_W;

	logic [RAW_IDX_W-1:0] raw_idx;
	logic [IDX_W-1:0]     sat_idx;
	logic                 advance;

	logic              srch_vld_s [STAGES+1];
	logic [IDX_W-1:0]  srch_idx_s [STAGES+1];
	logic [LOUD_W-1:0] srch_m_s   [STAGES+1];
	logic              srch_rst_s [STAGES+1];

	assign raw_idx = energy[ENERGY_W-1:3];
	assign sat_idx = (raw_idx > RAW_IDX_W'(VU_TABLE_DEPTH - 1)) ?
		IDX_W'(VU_TABLE_DEPTH - 1) : IDX_W'(raw_idx);

	assign advance  = !(srch_vld_s[STAGES] && mid_full);
	assign full     = !advance;
	assign mid_push = srch_vld_s[STAGES] && !mid_full;
	assign mid_item = '{restart: srch_rst_s[STAGES], loud: srch_m_s[STAGES]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= STAGES; j++) begin
				srch_vld_s[j] <= 1'b0;
			end
		end else if (advance) begin
			srch_vld_s[0] <= push;
			for (int j = 1; j <= STAGES; j++) begin
				srch_vld_s[j] <= srch_vld_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			srch_idx_s[0] <= sat_idx;
			srch_m_s[0]   <= '0;
			srch_rst_s[0] <= restart;
		end
	end

	for (genvar g = 1; g <= STAGES; g++) begin : g_step
		localparam int BIT = STAGES - g;

		logic [LOUD_W-1:0] cand;
		logic              hit;

		assign cand = srch_m_s[g-1] | LOUD_W'(1 << BIT);
		assign hit  = LOUD_BP[cand] <= BP_W'(srch_idx_s[g-1]);

		always_ff @(posedge clk) begin
			if (advance) begin
				srch_idx_s[g] <= srch_idx_s[g-1];
				srch_m_s[g]   <= hit ? cand : srch_m_s[g-1];
				srch_rst_s[g] <= srch_rst_s[g-1];
			end
		end
	end

endmodule

/* rtl/asd_back.sv */
// ----------------------------------------------------------------------------
// Adaptive silence detector back end
// Applies each loudness beat to the threshold state: learning during the
// parole period, window statistics and adaptation afterwards.
// ----------------------------------------------------------------------------
module asd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [asd_pkg::PAROLE_W-1:0]  learn_items,
	input  logic [asd_pkg::EVAL_W-1:0]    window_items,
	input  logic                          mid_empty,
	input  asd_pkg::mid_item_t            mid_item,
	output logic                          mid_pop,
	input  logic                          res_full,
	output logic                          res_push,
	output asd_pkg::res_item_t            res_item
);

	import asd_pkg::*;

	logic [THRESH_W-1:0] thresh_q;
	logic [PAROLE_W-1:0] parole_cnt_q;
	logic [EVAL_W-1:0]   window_cnt_q;
	logic [CNT_W-1:0]    below_cnt_q;
	logic [CNT_W-1:0]    above_cnt_q;
	logic [LOUD_W-1:0]   below_max_q;

	logic [THRESH_W-1:0] th;
	logic [PAROLE_W-1:0] pc;
	logic [EVAL_W-1:0]   wc;
	logic [CNT_W-1:0]    bc;
	logic [CNT_W-1:0]    ac;
	logic [LOUD_W-1:0]   bm;
	logic [THRESH_W-1:0] m9;

	logic [THRESH_W-1:0] th_n;
	logic [PAROLE_W-1:0] pc_n;
	logic [EVAL_W-1:0]   wc_n;
	logic [CNT_W-1:0]    bc_n;
	logic [CNT_W-1:0]    ac_n;
	logic [LOUD_W-1:0]   bm_n;
	logic                parole;

	logic [THRESH_W:0]   learn_t;
	logic [THRESH_W:0]   diff;
	logic [THRESH_W:0]   avg;
	logic [THRESH_W:0]   step;
	logic [CNT_W-1:0]    eval_w;

	assign mid_pop  = !mid_empty && !res_full;
	assign res_push = mid_pop;

	always_comb begin
		th = mid_item.restart ? '0 : thresh_q;
		pc = mid_item.restart ? '0 : parole_cnt_q;
		wc = mid_item.restart ? '0 : window_cnt_q;
		bc = mid_item.restart ? '0 : below_cnt_q;
		ac = mid_item.restart ? '0 : above_cnt_q;
		bm = mid_item.restart ? '0 : below_max_q;
		m9 = THRESH_W'(mid_item.loud);

		th_n = th;
		pc_n = pc;
		wc_n = wc;
		bc_n = bc;
		ac_n = ac;
		bm_n = bm;
		parole = pc < learn_items;
		eval_w = CNT_W'(window_items);

		diff = (THRESH_W + 1)'(m9) - (THRESH_W + 1)'(th);
		if (m9 > th) begin
			learn_t = (THRESH_W + 1)'(m9) + (diff >> 1);
		end else begin
			learn_t = (((THRESH_W + 1)'(m9) + (THRESH_W + 1)'(th)) >> 1) + 1'b1;
		end
		if (learn_t < (THRESH_W + 1)'(m9)) begin
			learn_t = (THRESH_W + 1)'(m9);
		end

		avg  = '0;
		step = '0;

		if (parole) begin
			th_n = (learn_t > (THRESH_W + 1)'(THRESH_MAX)) ? THRESH_MAX : learn_t[THRESH_W-1:0];
			pc_n = pc + 1'b1;
		end else begin
			if (m9 > th) begin
				if (ac < CNT_MAX) begin
					ac_n = ac + 1'b1;
				end
			end else if (m9 < th) begin
				if (mid_item.loud > bm) begin
					bm_n = mid_item.loud;
				end
				if (bc < CNT_MAX) begin
					bc_n = bc + 1'b1;
				end
			end
			if (wc == window_items) begin
				avg  = (((THRESH_W + 1)'(th) + (THRESH_W + 1)'(bm_n)) >> 1) + 1'b1;
				step = (THRESH_W + 1)'(th) + 1'b1;
				if (bc_n == eval_w) begin
					th_n = (avg > (THRESH_W + 1)'(THRESH_MAX)) ? THRESH_MAX : avg[THRESH_W-1:0];
				end else if (ac_n == eval_w || bc_n > ac_n) begin
					th_n = (step > (THRESH_W + 1)'(THRESH_MAX)) ? THRESH_MAX : step[THRESH_W-1:0];
				end
				wc   = '0;
				bm_n = '0;
				bc_n = '0;
				ac_n = '0;
			end
			wc_n = wc + 1'b1;
		end

		res_item = '{silent: m9 < th_n, threshold: th_n, in_parole: parole};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q     <= '0;
			parole_cnt_q <= '0;
			window_cnt_q <= '0;
			below_cnt_q  <= '0;
			above_cnt_q  <= '0;
			below_max_q  <= '0;
		end else if (mid_pop) begin
			thresh_q     <= th_n;
			parole_cnt_q <= pc_n;
			window_cnt_q <= wc_n;
			below_cnt_q  <= bc_n;
			above_cnt_q  <= ac_n;
			below_max_q  <= bm_n;
		end
	end

endmodule

/* rtl/adaptive_silence_detector_top.sv */
// ----------------------------------------------------------------------------
// Adaptive silence detector
// Marks audio blocks as silent against a threshold that adapts to the
// loudness of the stream.
// ----------------------------------------------------------------------------
// One block energy is accepted per clock cycle and one result leaves per
// cycle while the result side keeps popping. The energy is mapped to an
// 8-bit loudness by a nine-stage pipeline, an index register followed by
// eight stages that each settle one bit of the loudness; a four-beat queue
// then feeds the threshold logic, which handles one beat per cycle into a
// two-beat result queue. The loudness table needs no fill after reset, so
// the block accepts beats at once.
module adaptive_silence_detector_top #(
	parameter int VU_TABLE_DEPTH = asd_pkg::VU_TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [asd_pkg::ENERGY_W-1:0]    energy,
	input  logic                            restart,
	output logic                            empty,
	input  logic                            pop,
	output logic                            silent,
	output logic [asd_pkg::THRESH_W-1:0]    threshold,
	output logic                            in_parole,
	input  logic                            cfg_we,
	input  logic [asd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [asd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import asd_pkg::*;

	logic [PAROLE_W-1:0] parole_q;
	logic [EVAL_W-1:0]   eval_q;

	logic       mid_push;
	logic       mid_full;
	logic       mid_pop;
	logic       mid_empty;
	mid_item_t  mid_in;
	mid_item_t  mid_out;
	logic       res_push;
	logic       res_full;
	res_item_t  res_in;
	res_item_t  res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parole_q <= PAROLE_RST;
			eval_q   <= EVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PAROLE: parole_q <= cfg_data[PAROLE_W-1:0];
				CFG_EVAL:   eval_q   <= cfg_data[EVAL_W-1:0];
				default:    ;
			endcase
		end
	end

	asd_front #(
		.VU_TABLE_DEPTH(VU_TABLE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.energy   (energy),
		.restart  (restart),
		.mid_push (mid_push),
		.mid_item (mid_in),
		.mid_full (mid_full)
	);

	asd_fifo #(
		.WIDTH($bits(mid_item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_out),
		.empty  (mid_empty)
	);

	asd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.learn_items   (parole_q),
		.window_items  (eval_q),
		.mid_empty     (mid_empty),
		.mid_item      (mid_out),
		.mid_pop       (mid_pop),
		.res_full      (res_full),
		.res_push      (res_push),
		.res_item      (res_in)
	);

	asd_fifo #(
		.WIDTH($bits(res_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign silent    = res_out.silent;
	assign threshold = res_out.threshold;
	assign in_parole = res_out.in_parole;

endmodule

/* sim/adaptive_silence_detector_top_test.sv */
// ----------------------------------------------------------------------------
// Adaptive silence detector testbench
// Pushes block energies through the queue interface with random holds on
// both sides, predicts the silent flag, threshold and learning flag of every
// beat from an untimed model of the detector, and compares each popped beat
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module adaptive_silence_detector_top_test;

	import asd_pkg::*;

	localparam int LUT_DEPTH    = 4096;
	localparam int LOUD_CEIL    = 254;
	localparam int WATCH_LIMIT  = 3000;
	localparam int SETTLE_TICKS = 16;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [ENERGY_W-1:0]   energy = '0;
	logic                  restart = 1'b0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic                  silent;
	logic [THRESH_W-1:0]   threshold;
	logic                  in_parole;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_PAROLE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [7:0]  loud_lut [LUT_DEPTH];
	int unsigned learn_len, window_len;
	int unsigned thr, learn_cnt, win_cnt, quiet_cnt, loud_cnt, quiet_peak;
	res_item_t   expected_q [$];
	res_item_t   head_beat;
	int unsigned mismatches = 0;
	int unsigned idle_ticks = 0;
	int unsigned stall_left = 0;
	bit          idle_on = 1'b1;
	bit          idle_allowed = 1'b1;
	int unsigned floor_e = 0;
	int unsigned burst_left = 0;

	adaptive_silence_detector_top #(
		.VU_TABLE_DEPTH(LUT_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.energy   (energy),
		.restart  (restart),
		.empty    (empty),
		.pop      (pop),
		.silent   (silent),
		.threshold(threshold),
		.in_parole(in_parole),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial forever #4 clk = ~clk;

	// Loudness is floor(255*tanh(0.004 i)), found by exact integer tests on a
	// Q11.53 running power of e^(1/125).
	function automatic void build_loudness();
		logic [63:0]  term;
		logic [63:0]  growth;
		logic [63:0]  e_q53;
		logic [127:0] prod;
		int unsigned  n;
		int unsigned  k;
		term = 64'h8000_0000_0000_0000;
		growth = term;
		n = 1;
		while (term != 64'd0) begin
			term = term / 64'(125 * n);
			growth = growth + term;
			n++;
		end
		e_q53 = 64'd1 << 53;
		k = 0;
		loud_lut[0] = 8'd0;
		for (int i = 1; i < LUT_DEPTH; i++) begin
			if (k < LOUD_CEIL) begin
				prod = 128'(e_q53) * 128'(growth);
				e_q53 = prod[126:63];
				while (k < LOUD_CEIL &&
					128'(e_q53) * 128'(LOUD_CEIL - k) >= (128'(256 + k) << 53))
					k++;
			end
			loud_lut[i] = 8'(k);
		end
	endfunction

	function automatic void clear_detector();
		thr = 0;
		learn_cnt = 0;
		win_cnt = 0;
		quiet_cnt = 0;
		loud_cnt = 0;
		quiet_peak = 0;
	endfunction

	function automatic int unsigned cap_thr(int unsigned t);
		return (t > THRESH_MAX) ? THRESH_MAX : t;
	endfunction

	function automatic res_item_t predict_beat(logic [ENERGY_W-1:0] e, logic rs);
		res_item_t   r;
		int unsigned idx;
		int unsigned loud;
		int unsigned t;
		bit          learning;
		if (rs) begin
			clear_detector();
		end
		idx = e >> 3;
		if (idx > LUT_DEPTH - 1) begin
			idx = LUT_DEPTH - 1;
		end
		loud = loud_lut[idx];
		learning = 1'b0;
		if (learn_cnt < learn_len) begin
			if (loud > thr) begin
				t = loud + (loud - thr) / 2;
			end else begin
				t = (loud + thr) / 2 + 1;
			end
			if (t < loud) begin
				t = loud;
			end
			thr = cap_thr(t);
			learn_cnt = (learn_cnt + 1) & 32'hff;
			learning = 1'b1;
		end else begin
			if (loud > thr) begin
				if (loud_cnt < CNT_MAX) loud_cnt++;
			end else if (loud < thr) begin
				if (loud > quiet_peak) quiet_peak = loud;
				if (quiet_cnt < CNT_MAX) quiet_cnt++;
			end
			if (win_cnt == window_len) begin
				if (quiet_cnt == window_len) begin
					thr = cap_thr((thr + quiet_peak) / 2 + 1);
				end else if (loud_cnt == window_len || quiet_cnt > loud_cnt) begin
					thr = cap_thr(thr + 1);
				end
				win_cnt = 0;
				quiet_peak = 0;
				quiet_cnt = 0;
				loud_cnt = 0;
			end
			win_cnt = (win_cnt + 1) & 32'h3ff;
		end
		r.silent = loud < thr;
		r.threshold = THRESH_W'(thr);
		r.in_parole = learning;
		return r;
	endfunction

	// Mostly a steady noise floor with small jitter, broken by bursts of
	// speech, the odd full-range value and both extremes.
	function automatic logic [ENERGY_W-1:0] gen_energy();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (burst_left != 0) begin
			burst_left--;
			return ENERGY_W'($urandom_range(floor_e + 400, 14000));
		end
		if (pick < 4) begin
			burst_left = $urandom_range(1, 40);
		end
		if (pick < 10) begin
			return ENERGY_W'($urandom);
		end
		if (pick < 13) begin
			return pick[0] ? 16'hffff : 16'h0000;
		end
		return ENERGY_W'(floor_e + $urandom_range(0, floor_e / 8 + 16));
	endfunction

	task automatic send_item(logic [ENERGY_W-1:0] e, logic rs);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		push <= 1'b1;
		energy <= e;
		restart <= rs;
		do @(posedge clk); while (full);
		expected_q.push_back(predict_beat(e, rs));
	endtask

	task automatic run_stream(int unsigned count, int unsigned restart_odds);
		for (int unsigned n = 0; n < count; n++) begin
			if (idle_allowed && n % 100 == 0) begin
				idle_on = $urandom_range(0, 3) != 0;
			end
			send_item(gen_energy(), $urandom_range(1, restart_odds) == 1);
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic set_detector(int unsigned parole_v, int unsigned eval_v);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_PAROLE;
		cfg_data <= CFG_DATA_W'(parole_v);
		@(posedge clk);
		cfg_index <= CFG_EVAL;
		cfg_data <= CFG_DATA_W'(eval_v);
		@(posedge clk);
		cfg_we <= 1'b0;
		learn_len = parole_v & 32'hff;
		window_len = eval_v & 32'h3ff;
		@(posedge clk);
	endtask

	task automatic test_directed();
		logic [ENERGY_W:0] steps [22] = '{
			17'h0_0000, 17'h0_ffff, 17'h0_0007, 17'h0_0008, 17'h0_7fff, 17'h0_8000,
			17'h0_7ff8, 17'h0_5555, 17'h0_aaaa, 17'h0_0064, 17'h0_0fa0, 17'h1_04b0,
			17'h0_04b0, 17'h0_0032, 17'h0_0032, 17'h0_2328, 17'h0_0014, 17'h0_0014,
			17'h0_0000, 17'h0_ffff, 17'h0_03e8, 17'h0_0000
		};
		for (int i = 0; i < 22; i++) begin
			send_item(steps[i][ENERGY_W-1:0], steps[i][ENERGY_W]);
		end
	endtask

	task automatic test_fast_windows();
		set_detector(1, 1);
		floor_e = $urandom_range(0, 3000);
		run_stream(150, 60);
	endtask

	task automatic test_zero_settings();
		set_detector(0, 0);
		for (int i = 0; i < 4; i++) begin
			floor_e = $urandom_range(0, 4000);
			send_item(gen_energy(), 1'b1);
			run_stream(20, 1000);
		end
	endtask

	task automatic test_long_windows();
		set_detector(255, 1023);
		floor_e = $urandom_range(0, 2000);
		send_item(gen_energy(), 1'b1);
		run_stream(1300, 100000);
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 4; p++) begin
			if (p == 0) begin
				set_detector($urandom_range(1, 255), $urandom_range(1, 1023));
			end else begin
				set_detector($urandom_range(1, 20), $urandom_range(1, 40));
			end
			floor_e = $urandom_range(0, 4000);
			run_stream(75, 250);
			if (p == 1) begin
				settle();
			end
			run_stream(75, 250);
		end
	endtask

	task automatic test_back_to_back();
		idle_allowed = 1'b0;
		idle_on = 1'b0;
		set_detector($urandom_range(2, 12), $urandom_range(4, 30));
		floor_e = $urandom_range(0, 4000);
		run_stream(150, 200);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			pop <= 1'b0;
			stall_left <= $urandom_range(0, 12);
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$display("%0t: beat with none expected, actual %0b %0d %0b",
						$time, silent, threshold, in_parole);
					mismatches++;
				end else begin
					head_beat = expected_q.pop_front();
					if (silent !== head_beat.silent) begin
						$display("%0t: silent expected %0b actual %0b",
							$time, head_beat.silent, silent);
						mismatches++;
					end
					if (threshold !== head_beat.threshold) begin
						$display("%0t: threshold expected %0d actual %0d",
							$time, head_beat.threshold, threshold);
						mismatches++;
					end
					if (in_parole !== head_beat.in_parole) begin
						$display("%0t: in_parole expected %0b actual %0b",
							$time, head_beat.in_parole, in_parole);
						mismatches++;
					end
				end
			end
			if ((push && !full) || (pop && !empty)) begin
				idle_ticks = 0;
			end else begin
				idle_ticks++;
			end
			if (idle_ticks >= WATCH_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		build_loudness();
		clear_detector();
		learn_len = PAROLE_RST;
		window_len = EVAL_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fast_windows();
		test_zero_settings();
		test_long_windows();
		test_random_settings();
		test_back_to_back();
		settle();
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* adaptive_silence_detector_top.f */
rtl/asd_pkg.sv
rtl/asd_fifo.sv
rtl/asd_front.sv
rtl/asd_back.sv
rtl/adaptive_silence_detector_top.sv
sim/adaptive_silence_detector_top_test.sv
